// ===== rtl/core/cialu_pkg.sv =====
`timescale 1ns / 1ps
package cialu_pkg;

  localparam int DataWidthDef = 64;
  localparam int MaxWidth     = 64;

  // opcodes
  localparam logic [4:0] OP_EQ   = 5'd0;
  localparam logic [4:0] OP_NE   = 5'd1;
  localparam logic [4:0] OP_LOR  = 5'd2;
  localparam logic [4:0] OP_LAND = 5'd3;
  localparam logic [4:0] OP_LT   = 5'd4;
  localparam logic [4:0] OP_GT   = 5'd5;
  localparam logic [4:0] OP_LE   = 5'd6;
  localparam logic [4:0] OP_GE   = 5'd7;
  localparam logic [4:0] OP_OR   = 5'd8;
  localparam logic [4:0] OP_XOR  = 5'd9;
  localparam logic [4:0] OP_AND  = 5'd10;
  localparam logic [4:0] OP_ADD  = 5'd11;
  localparam logic [4:0] OP_SUB  = 5'd12;
  localparam logic [4:0] OP_MUL  = 5'd13;
  localparam logic [4:0] OP_SHL  = 5'd14;
  localparam logic [4:0] OP_SHR  = 5'd15;
  localparam logic [4:0] OP_DIV  = 5'd16;
  localparam logic [4:0] OP_MOD  = 5'd17;

  // result source at the end of the cell row
  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_MUL    = 2'd1;
  localparam logic [1:0] KIND_DIV    = 2'd2;
  localparam logic [1:0] KIND_MOD    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [63:0] left_value;
    logic        left_signed;
    logic [63:0] right_value;
    logic        right_signed;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        result_signed;
    logic [1:0]  status;
  } out_beat_t;

  typedef struct packed {
    logic                valid;
    logic [1:0]          kind;
    logic                rsig;
    logic [1:0]          status;
    logic                dzero;
    logic                negq;
    logic                negr;
    logic [MaxWidth-1:0] simple;
    logic [MaxWidth-1:0] mcand;
    logic [MaxWidth-1:0] mplier;
    logic [MaxWidth-1:0] acc;
    logic [MaxWidth-1:0] dvd;
    logic [MaxWidth-1:0] dsor;
    logic [MaxWidth-1:0] rem;
  } stage_t;

endpackage

// ===== rtl/core/cialu_pre.sv =====
`timescale 1ns / 1ps
module cialu_pre #(
  parameter int DATA_WIDTH = cialu_pkg::DataWidthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_take,
  input  cialu_pkg::in_beat_t beat,
  output cialu_pkg::stage_t   st_r
);

  localparam logic [63:0] MASK = {64{1'b1}} >> (64 - DATA_WIDTH);
  localparam logic [63:0] SIGN = 64'd1 << (DATA_WIDTH - 1);
  localparam logic [63:0] WLIM = 64'(DATA_WIDTH - 1);

  logic [63:0] a, b, sa, ma, mb, res;
  logic        both, an, bn, big, lt, gt;
  logic [1:0]  kind;
  logic        rsig;
  cialu_pkg::stage_t st_nxt;

  // decode and work out every simple operation
  always_comb begin
    a    = beat.left_value & MASK;
    b    = beat.right_value & MASK;
    both = beat.left_signed & beat.right_signed;
    an   = a[DATA_WIDTH-1];
    bn   = b[DATA_WIDTH-1];
    sa   = an ? (a | ~MASK) : a;
    big  = b > WLIM;
    lt   = both ? ((a ^ SIGN) < (b ^ SIGN)) : (a < b);
    gt   = both ? ((b ^ SIGN) < (a ^ SIGN)) : (a > b);
    ma   = (both && an) ? ((64'd0 - a) & MASK) : a;
    mb   = (both && bn) ? ((64'd0 - b) & MASK) : b;
    res  = '0;
    kind = cialu_pkg::KIND_SIMPLE;
    rsig = 1'b1;
    unique case (beat.opcode)
      cialu_pkg::OP_EQ:   res = {63'd0, a == b};
      cialu_pkg::OP_NE:   res = {63'd0, a != b};
      cialu_pkg::OP_LOR:  res = {63'd0, (a != 0) || (b != 0)};
      cialu_pkg::OP_LAND: res = {63'd0, (a != 0) && (b != 0)};
      cialu_pkg::OP_LT:   res = {63'd0, lt};
      cialu_pkg::OP_GT:   res = {63'd0, gt};
      cialu_pkg::OP_LE:   res = {63'd0, !gt};
      cialu_pkg::OP_GE:   res = {63'd0, !lt};
      cialu_pkg::OP_OR:  begin res = a | b; rsig = both; end
      cialu_pkg::OP_XOR: begin res = a ^ b; rsig = both; end
      cialu_pkg::OP_AND: begin res = a & b; rsig = both; end
      cialu_pkg::OP_ADD: begin res = (a + b) & MASK; rsig = both; end
      cialu_pkg::OP_SUB: begin res = (a - b) & MASK; rsig = both; end
      cialu_pkg::OP_MUL: begin kind = cialu_pkg::KIND_MUL; rsig = both; end
      cialu_pkg::OP_SHL: begin
        res  = big ? 64'd0 : ((a << b[5:0]) & MASK);
        rsig = both;
      end
      cialu_pkg::OP_SHR: begin
        if (both && an) res = big ? MASK : (~((~sa) >> b[5:0]) & MASK);
        else            res = big ? 64'd0 : (a >> b[5:0]);
        rsig = both;
      end
      cialu_pkg::OP_DIV: begin kind = cialu_pkg::KIND_DIV; rsig = both; end
      cialu_pkg::OP_MOD: begin kind = cialu_pkg::KIND_MOD; rsig = both; end
      default: rsig = 1'b0;
    endcase
    st_nxt        = '0;
    st_nxt.valid  = in_take;
    st_nxt.kind   = kind;
    st_nxt.rsig   = rsig;
    st_nxt.dzero  = (b == 0);
    st_nxt.negq   = both & (an ^ bn);
    st_nxt.negr   = both & an;
    st_nxt.simple = res;
    st_nxt.mcand  = a;
    st_nxt.mplier = b;
    st_nxt.dvd    = ma;
    st_nxt.dsor   = mb;
    if ((beat.opcode == cialu_pkg::OP_DIV) || (beat.opcode == cialu_pkg::OP_MOD)) begin
      if (b == 0) st_nxt.status = cialu_pkg::ST_DIV0;
      else if (both && (a == SIGN) && (b == MASK)) st_nxt.status = cialu_pkg::ST_OVF;
      else st_nxt.status = cialu_pkg::ST_OK;
    end else begin
      st_nxt.status = cialu_pkg::ST_OK;
    end
  end

  // hold valid under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (adv) begin
      st_r.valid <= st_nxt.valid;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r.kind   <= st_nxt.kind;
      st_r.rsig   <= st_nxt.rsig;
      st_r.status <= st_nxt.status;
      st_r.dzero  <= st_nxt.dzero;
      st_r.negq   <= st_nxt.negq;
      st_r.negr   <= st_nxt.negr;
      st_r.simple <= st_nxt.simple;
      st_r.mcand  <= st_nxt.mcand;
      st_r.mplier <= st_nxt.mplier;
      st_r.acc    <= st_nxt.acc;
      st_r.dvd    <= st_nxt.dvd;
      st_r.dsor   <= st_nxt.dsor;
      st_r.rem    <= st_nxt.rem;
    end
  end

endmodule

// ===== rtl/core/cialu_cell.sv =====
`timescale 1ns / 1ps
module cialu_cell #(
  parameter int DATA_WIDTH = cialu_pkg::DataWidthDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  cialu_pkg::stage_t cur,
  output cialu_pkg::stage_t st_r
);

  localparam logic [63:0] MASK = {64{1'b1}} >> (64 - DATA_WIDTH);

  logic [64:0] rem_sh, diff;
  logic        ge;
  cialu_pkg::stage_t st_nxt;

  // one multiplier bit and one quotient bit per cell
  always_comb begin
    rem_sh = {cur.rem, cur.dvd[DATA_WIDTH-1]};
    diff   = rem_sh - {1'b0, cur.dsor};
    ge     = !diff[64];
    st_nxt        = cur;
    st_nxt.acc    = cur.mplier[0] ? ((cur.acc + cur.mcand) & MASK) : cur.acc;
    st_nxt.mcand  = (cur.mcand << 1) & MASK;
    st_nxt.mplier = cur.mplier >> 1;
    st_nxt.rem    = ge ? diff[63:0] : rem_sh[63:0];
    st_nxt.dvd    = ((cur.dvd << 1) | {63'd0, ge}) & MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (adv) begin
      st_r.valid <= st_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r.kind   <= st_nxt.kind;
      st_r.rsig   <= st_nxt.rsig;
      st_r.status <= st_nxt.status;
      st_r.dzero  <= st_nxt.dzero;
      st_r.negq   <= st_nxt.negq;
      st_r.negr   <= st_nxt.negr;
      st_r.simple <= st_nxt.simple;
      st_r.mcand  <= st_nxt.mcand;
      st_r.mplier <= st_nxt.mplier;
      st_r.acc    <= st_nxt.acc;
      st_r.dvd    <= st_nxt.dvd;
      st_r.dsor   <= st_nxt.dsor;
      st_r.rem    <= st_nxt.rem;
    end
  end

endmodule

// ===== rtl/core/c_integer_alu_64.sv =====
`timescale 1ns / 1ps
// Two-operand integer ALU with C signedness rules. It takes one beat per
// cycle unless the output stalls, and returns results in order through a
// decode stage, a row of DATA_WIDTH cells that each retire one multiplier
// bit and one quotient bit, and an output register that applies the final
// sign. A stalled output holds the whole row; every operation, simple or
// not, travels the same row, so results never overtake one another.
module c_integer_alu_64 #(
  parameter int DATA_WIDTH = cialu_pkg::DataWidthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cialu_pkg::in_beat_t  in_beat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cialu_pkg::out_beat_t out_beat
);

  localparam logic [63:0] MASK = {64{1'b1}} >> (64 - DATA_WIDTH);

  cialu_pkg::stage_t    chain [0:DATA_WIDTH];
  cialu_pkg::out_beat_t out_beat_r, out_beat_nxt;
  logic                 out_valid_r;
  logic                 adv;
  logic [63:0]          q, r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  cialu_pre #(.DATA_WIDTH(DATA_WIDTH)) u_pre (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_take(in_valid),
    .beat(in_beat), .st_r(chain[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    cialu_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv), .cur(chain[i]), .st_r(chain[i+1])
    );
  end

  // apply the final sign and pick the result
  always_comb begin
    q = chain[DATA_WIDTH].negq ? ((64'd0 - chain[DATA_WIDTH].dvd) & MASK)
                               : chain[DATA_WIDTH].dvd;
    r = chain[DATA_WIDTH].negr ? ((64'd0 - chain[DATA_WIDTH].rem) & MASK)
                               : chain[DATA_WIDTH].rem;
    out_beat_nxt.result_signed = chain[DATA_WIDTH].rsig;
    out_beat_nxt.status        = chain[DATA_WIDTH].status;
    unique case (chain[DATA_WIDTH].kind)
      cialu_pkg::KIND_MUL: out_beat_nxt.result_value = chain[DATA_WIDTH].acc;
      cialu_pkg::KIND_DIV: out_beat_nxt.result_value = chain[DATA_WIDTH].dzero ? 64'd0 : q;
      cialu_pkg::KIND_MOD: out_beat_nxt.result_value = chain[DATA_WIDTH].dzero ? 64'd0 : r;
      default:             out_beat_nxt.result_value = chain[DATA_WIDTH].simple;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[DATA_WIDTH].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// ===== rtl/core/cialu_checker.sv =====
`timescale 1ns / 1ps
module cialu_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input cialu_pkg::out_beat_t out_beat
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("stalled result beat changed");

  // input waits only while a result waits
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without output stall");

  // status never takes the unused code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.status <= cialu_pkg::ST_OVF)
    else $error("bad status code");

  // divide by zero gives zero
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_beat.status == cialu_pkg::ST_DIV0) |-> out_beat.result_value == 64'd0)
    else $error("divide by zero result not zero");

  // overflow only on a signed divide or modulo
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_beat.status == cialu_pkg::ST_OVF) |-> out_beat.result_signed)
    else $error("overflow on unsigned result");

endmodule

bind c_integer_alu_64 cialu_checker u_cialu_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int Latency = cialu_pkg::DataWidthDef + 2;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  cialu_pkg::in_beat_t  in_beat = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cialu_pkg::out_beat_t out_beat;

  cialu_pkg::out_beat_t alu_results_q[$];
  int                   fail_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;

  c_integer_alu_64 i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

  always #10 clk = ~clk;

  // Work out what the ALU should return for one beat
  function automatic cialu_pkg::out_beat_t alu_predict(cialu_pkg::in_beat_t b);
    cialu_pkg::out_beat_t r;
    logic [63:0] a, c, q, m, ma, mb;
    logic        both;
    logic signed [63:0] sa, sc;
    a = b.left_value;
    c = b.right_value;
    sa = a;
    sc = c;
    both = b.left_signed & b.right_signed;
    r.result_value = '0;
    r.result_signed = both;
    r.status = cialu_pkg::ST_OK;
    case (b.opcode)
      cialu_pkg::OP_EQ:   r.result_value = 64'(a == c);
      cialu_pkg::OP_NE:   r.result_value = 64'(a != c);
      cialu_pkg::OP_LOR:  r.result_value = 64'((a != 0) || (c != 0));
      cialu_pkg::OP_LAND: r.result_value = 64'((a != 0) && (c != 0));
      cialu_pkg::OP_LT:   r.result_value = 64'(both ? (sa < sc) : (a < c));
      cialu_pkg::OP_GT:   r.result_value = 64'(both ? (sa > sc) : (a > c));
      cialu_pkg::OP_LE:   r.result_value = 64'(both ? (sa <= sc) : (a <= c));
      cialu_pkg::OP_GE:   r.result_value = 64'(both ? (sa >= sc) : (a >= c));
      cialu_pkg::OP_OR:   r.result_value = a | c;
      cialu_pkg::OP_XOR:  r.result_value = a ^ c;
      cialu_pkg::OP_AND:  r.result_value = a & c;
      cialu_pkg::OP_ADD:  r.result_value = a + c;
      cialu_pkg::OP_SUB:  r.result_value = a - c;
      cialu_pkg::OP_MUL:  r.result_value = a * c;
      cialu_pkg::OP_SHL:  r.result_value = (c >= 64) ? '0 : a << c[5:0];
      cialu_pkg::OP_SHR: begin
        if (both) r.result_value = (c >= 64) ? {64{a[63]}} : 64'(sa >>> c[5:0]);
        else r.result_value = (c >= 64) ? '0 : a >> c[5:0];
      end
      cialu_pkg::OP_DIV, cialu_pkg::OP_MOD: begin
        if (c == 0) begin
          r.status = cialu_pkg::ST_DIV0;
        end else if (both) begin
          ma = a[63] ? -a : a;
          mb = c[63] ? -c : c;
          q = ma / mb;
          m = ma % mb;
          if (a == 64'h8000_0000_0000_0000 && c == '1) r.status = cialu_pkg::ST_OVF;
          if (b.opcode == cialu_pkg::OP_DIV) r.result_value = (a[63] ^ c[63]) ? -q : q;
          else r.result_value = a[63] ? -m : m;
        end else begin
          r.result_value = (b.opcode == cialu_pkg::OP_DIV) ? a / c : a % c;
        end
      end
      default: r.result_signed = 1'b0;
    endcase
    if (b.opcode <= cialu_pkg::OP_GE) r.result_signed = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  // Send one beat, hold it until accepted, and log its expected result
  task automatic send_beat(cialu_pkg::in_beat_t b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    alu_results_q.push_back(alu_predict(b));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid after the last beat of a burst
  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    cialu_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (alu_results_q.size() == 0) begin
        report_mismatch("unexpected beat", out_beat.result_value, '0);
      end else begin
        want = alu_results_q.pop_front();
        if (out_beat.result_value !== want.result_value)
          report_mismatch("result_value", out_beat.result_value, want.result_value);
        if (out_beat.result_signed !== want.result_signed)
          report_mismatch("result_signed", 64'(out_beat.result_signed),
                          64'(want.result_signed));
        if (out_beat.status !== want.status)
          report_mismatch("status", 64'(out_beat.status), 64'(want.status));
      end
    end
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return 64'($urandom_range(70));
      5: return -64'($urandom_range(70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cialu_pkg::in_beat_t random_beat();
    cialu_pkg::in_beat_t b;
    b.opcode = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(17));
    b.left_value = pick_operand();
    b.right_value = pick_operand();
    b.left_signed = $urandom_range(3) != 0;
    b.right_signed = $urandom_range(3) != 0;
    return b;
  endfunction

  task automatic wait_drained();
    while (alu_results_q.size() != 0) @(posedge clk);
  endtask

  // Opcodes 0-19 at edge operands, plus divide, shift, bad-op corners
  task automatic test_directed();
    cialu_pkg::in_beat_t b;
    logic [63:0] ops[4] = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'd64};
    for (int op = 0; op < 20; op++) begin
      b.opcode = 5'(op);
      b.left_value = ops[op % 4];
      b.right_value = ops[(op + 1) % 4];
      b.left_signed = op[0];
      b.right_signed = 1'b1;
      send_beat(b);
    end
    b = '{cialu_pkg::OP_DIV, 64'h8000_0000_0000_0000, 1'b1, '1, 1'b1};
    send_beat(b);
    b.opcode = cialu_pkg::OP_MOD;
    send_beat(b);
    b = '{cialu_pkg::OP_MOD, 64'd7, 1'b0, 64'd0, 1'b0};
    send_beat(b);
    b = '{cialu_pkg::OP_SHR, '1, 1'b1, 64'hffff_ffff_ffff_fffe, 1'b1};
    send_beat(b);
    b = '{5'd31, '1, 1'b1, '1, 1'b1};
    send_beat(b);
    end_burst();
    // hold off until the pipe is empty
    wait_drained();
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) send_beat(random_beat());
    end_burst();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400, 0, 0);
    test_random(350, 64, 0);
    test_random(350, 0, 64);
    test_random(350, 38, 38);
    recv_stall_pct = 0;
    wait_drained();
    repeat (Latency + 10) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
